// ----- hdl/tfli_pkg.sv -----
// Package for the FIFO-replacement translation buffer.
// Holds sizes, widths and the controller/datapath command type.
// No dependencies.
package tfli_pkg;

  localparam int ENTRIES    = 8;
  localparam int PAGE_BITS  = 20;
  localparam int FRAME_BITS = 20;
  localparam int CNT_BITS   = 32;
  localparam int IDX_BITS   = $clog2(ENTRIES);
  localparam int FILL_BITS  = $clog2(ENTRIES + 1);

  // operation codes of the func field
  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_INSERT = 1'b1;

  // command from controller to datapath
  typedef struct packed {
    logic load;    // a transaction is accepted this cycle
    logic insert;  // accepted item is an insert, else a lookup
  } tfli_cmd_t;

endpackage

// ----- hdl/tfli_if.sv -----
// Channel interfaces for the translation buffer: request and result.
// Depends on tfli_pkg for field widths.
interface tfli_in_if import tfli_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  func;
  logic [PAGE_BITS-1:0]  page_number;
  logic [FRAME_BITS-1:0] frame_number;

  modport source (output valid, func, page_number, frame_number, input ready);
  modport sink   (input valid, func, page_number, frame_number, output ready);
endinterface

interface tfli_out_if import tfli_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [FRAME_BITS-1:0] found_frame;
  logic [CNT_BITS-1:0]   lookup_total;
  logic [CNT_BITS-1:0]   hit_total;

  modport source (output valid, hit, found_frame, lookup_total, hit_total, input ready);
  modport sink   (input valid, hit, found_frame, lookup_total, hit_total, output ready);
endinterface

// ----- hdl/tfli_ctrl.sv -----
// Controller of the translation buffer: handshake and result-hold state.
// Depends on tfli_pkg.
module tfli_ctrl import tfli_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_func,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output tfli_cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;  // no result waiting
  localparam logic ST_HOLD = 1'b1;  // result register full

  logic state;
  logic state_next;
  logic accept;

  // take a new item when the result register is empty or drains now
  assign in_ready  = !rst && ((state == ST_IDLE) || out_ready);
  assign accept    = in_valid && in_ready;
  assign out_valid = (state == ST_HOLD);

  assign cmd.load   = accept;
  assign cmd.insert = (in_func == FUNC_INSERT);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_HOLD;
      end
      ST_HOLD: begin
        if (accept) state_next = ST_HOLD;
        else if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- hdl/tfli_dp.sv -----
// Datapath of the translation buffer: entry row, tag compare, FIFO fill
// and shift, running counters and the result register. Depends on tfli_pkg.
module tfli_dp import tfli_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  tfli_cmd_t             cmd,
  input  logic [PAGE_BITS-1:0]  page_number,
  input  logic [FRAME_BITS-1:0] frame_number,
  output logic                  hit,
  output logic [FRAME_BITS-1:0] found_frame,
  output logic [CNT_BITS-1:0]   lookup_total,
  output logic [CNT_BITS-1:0]   hit_total
);

  logic [PAGE_BITS-1:0]  entry_tag   [ENTRIES];
  logic [FRAME_BITS-1:0] entry_frame [ENTRIES];
  logic [ENTRIES-1:0]    entry_valid;
  logic [FILL_BITS-1:0]  fill_count;
  logic [CNT_BITS-1:0]   lookup_counter;
  logic [CNT_BITS-1:0]   hit_counter;

  logic [ENTRIES-1:0]    match;
  logic                  any_match;
  logic [IDX_BITS-1:0]   match_idx;
  logic                  full;
  logic [IDX_BITS-1:0]   fill_slot;
  logic                  do_lookup;
  logic                  do_insert;

  assign do_lookup = cmd.load && !cmd.insert;
  assign do_insert = cmd.load && cmd.insert;

  // parallel tag compare
  always_comb begin
    for (int k = 0; k < ENTRIES; k++) begin
      match[k] = entry_valid[k] && (entry_tag[k] == page_number);
    end
  end

  // lowest matching index wins
  always_comb begin
    match_idx = '0;
    for (int k = ENTRIES - 1; k >= 0; k--) begin
      if (match[k]) match_idx = IDX_BITS'(k);
    end
  end
  assign any_match = |match;

  assign full      = (fill_count == FILL_BITS'(ENTRIES));
  assign fill_slot = IDX_BITS'(ENTRIES - 1) - fill_count[IDX_BITS-1:0];

  // entry payload: fill top-down, then shift toward the top index
  always_ff @(posedge clk) begin
    if (do_insert) begin
      if (full) begin
        for (int k = ENTRIES - 1; k > 0; k--) begin
          entry_tag[k]   <= entry_tag[k-1];
          entry_frame[k] <= entry_frame[k-1];
        end
        entry_tag[0]   <= page_number;
        entry_frame[0] <= frame_number;
      end else begin
        entry_tag[fill_slot]   <= page_number;
        entry_frame[fill_slot] <= frame_number;
      end
    end
  end

  // valid bits, fill count and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid    <= '0;
      fill_count     <= '0;
      lookup_counter <= '0;
      hit_counter    <= '0;
    end else begin
      if (do_insert) begin
        if (full) begin
          entry_valid <= {entry_valid[ENTRIES-2:0], 1'b1};
        end else begin
          entry_valid[fill_slot] <= 1'b1;
          fill_count             <= fill_count + 1'b1;
        end
      end
      if (do_lookup) begin
        lookup_counter <= lookup_counter + 1'b1;
        if (any_match) hit_counter <= hit_counter + 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hit         <= do_lookup && any_match;
      found_frame <= (do_lookup && any_match) ? entry_frame[match_idx] : '0;
    end
  end

  // counters already hold the totals of the last accepted item
  assign lookup_total = lookup_counter;
  assign hit_total    = hit_counter;

endmodule

// ----- hdl/tlb_fifo_lookup_insert.sv -----
// Top level of the 8-entry fully associative translation buffer.
// Depends on tfli_pkg, tfli_if, tfli_ctrl and tfli_dp.
//
// Usage:
//   in_ch carries one request per transaction: func selects lookup or
//   insert, page_number is the tag, frame_number is stored on insert.
//   out_ch returns exactly one result per request: hit, found_frame and
//   the running lookup and hit totals after that request.
//   A request accepted at a clock edge has its result valid in the next
//   cycle. Throughput is one request per cycle unless the receiver stalls;
//   the entry-row compare and the FIFO update happen in the accepting cycle.
//   Lookups return the lowest-index valid match. Inserts fill from the top
//   index down; once full, entries shift up and the oldest drops out.
//   Reset (synchronous, active high) clears valid bits, fill count and
//   both counters; in_ch.ready stays low while reset is high.
//   When the receiver stalls, the result is held in the output register and
//   in_ch.ready drops until that result is taken; a result taken in the
//   same cycle lets the next request in without a bubble.
module tlb_fifo_lookup_insert import tfli_pkg::*; (
  input  logic clk,
  input  logic rst,
  tfli_in_if.sink    in_ch,
  tfli_out_if.source out_ch
);

  tfli_cmd_t cmd;

  tfli_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_func   (in_ch.func),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  tfli_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .page_number  (in_ch.page_number),
    .frame_number (in_ch.frame_number),
    .hit          (out_ch.hit),
    .found_frame  (out_ch.found_frame),
    .lookup_total (out_ch.lookup_total),
    .hit_total    (out_ch.hit_total)
  );

endmodule

// ----- hdl/tfli_checker.sv -----
// Port-level checks for the translation buffer, bound to the top level.
// Depends on tfli_pkg and tlb_fifo_lookup_insert.
module tfli_checker import tfli_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  in_func,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  hit,
  input logic [FRAME_BITS-1:0] found_frame,
  input logic [CNT_BITS-1:0]   lookup_total
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  // every accepted request yields a result next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> out_valid)
    else $error("no result after accepted request");

  // inserts report no hit and a zero frame
  a_insert_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (in_func == FUNC_INSERT)) |=> (!hit && (found_frame == '0)))
    else $error("insert reported a hit");

  // a lookup bumps the lookup total by one
  a_lookup_count: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (in_func == FUNC_LOOKUP))
      |=> (lookup_total == CNT_BITS'($past(lookup_total) + 1'b1)))
    else $error("lookup total did not advance");

endmodule

bind tlb_fifo_lookup_insert tfli_checker u_tfli_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_func      (in_ch.func),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .hit          (out_ch.hit),
  .found_frame  (out_ch.found_frame),
  .lookup_total (out_ch.lookup_total)
);

// ----- tb/sv/tfli_tb_pkg.sv -----
// Scoreboard for the FIFO-replacement translation buffer testbench.
// Keeps a mirror of the entry row and counters and checks each returned result.
// Depends on tfli_pkg for sizes, widths and func codes.
package tfli_tb_pkg;
  import tfli_pkg::*;

  typedef struct packed {
    logic                  hit;
    logic [FRAME_BITS-1:0] found_frame;
    logic [CNT_BITS-1:0]   lookup_total;
    logic [CNT_BITS-1:0]   hit_total;
  } tlb_result_t;

  class tlb_scoreboard;
    logic [PAGE_BITS-1:0]  tag_row[ENTRIES];
    logic [FRAME_BITS-1:0] frame_row[ENTRIES];
    bit                    valid_row[ENTRIES];
    int unsigned           filled;
    logic [CNT_BITS-1:0]   lookups;
    logic [CNT_BITS-1:0]   hits;
    tlb_result_t           awaited[$];
    int unsigned           failures;

    function new();
      foreach (tag_row[k]) begin
        tag_row[k]   = '0;
        frame_row[k] = '0;
        valid_row[k] = 1'b0;
      end
      filled   = 0;
      lookups  = '0;
      hits     = '0;
      failures = 0;
    endfunction

    // Apply one accepted request to the mirror and queue the result it yields.
    function void note_request(logic func, logic [PAGE_BITS-1:0] page,
                               logic [FRAME_BITS-1:0] frame);
      tlb_result_t res;
      bit          matched;
      res     = '0;
      matched = 1'b0;
      if (func == FUNC_LOOKUP) begin
        lookups++;
        // lowest index wins among duplicate tags
        for (int k = 0; k < ENTRIES; k++) begin
          if (!matched && valid_row[k] && tag_row[k] == page) begin
            matched         = 1'b1;
            res.hit         = 1'b1;
            res.found_frame = frame_row[k];
            hits++;
          end
        end
      end else if (filled >= ENTRIES) begin
        // full: shift toward the top, oldest drops, new pair at index 0
        for (int k = ENTRIES - 1; k > 0; k--) begin
          tag_row[k]   = tag_row[k-1];
          frame_row[k] = frame_row[k-1];
          valid_row[k] = valid_row[k-1];
        end
        tag_row[0]   = page;
        frame_row[0] = frame;
        valid_row[0] = 1'b1;
      end else begin
        // still filling from the top index down
        tag_row[ENTRIES-1-filled]   = page;
        frame_row[ENTRIES-1-filled] = frame;
        valid_row[ENTRIES-1-filled] = 1'b1;
        filled++;
      end
      res.lookup_total = lookups;
      res.hit_total    = hits;
      awaited.push_back(res);
    endfunction

    function void field_mismatch(string field, time at_ns,
                                 logic [CNT_BITS-1:0] want, logic [CNT_BITS-1:0] got);
      failures++;
      $display("%0d ns: %s expected %h got %h", at_ns, field, want, got);
    endfunction

    // Compare one accepted result with the oldest pending expectation.
    function void check_result(tlb_result_t got, time at_ns);
      tlb_result_t want;
      if (awaited.size() == 0) begin
        failures++;
        $display("%0d ns: unexpected result, expected none, got hit %b frame %h totals %h/%h",
                 at_ns, got.hit, got.found_frame, got.lookup_total, got.hit_total);
        return;
      end
      want = awaited.pop_front();
      if (got.hit !== want.hit)
        field_mismatch("hit", at_ns, CNT_BITS'(want.hit), CNT_BITS'(got.hit));
      if (got.found_frame !== want.found_frame)
        field_mismatch("found_frame", at_ns, CNT_BITS'(want.found_frame),
                       CNT_BITS'(got.found_frame));
      if (got.lookup_total !== want.lookup_total)
        field_mismatch("lookup_total", at_ns, want.lookup_total, got.lookup_total);
      if (got.hit_total !== want.hit_total)
        field_mismatch("hit_total", at_ns, want.hit_total, got.hit_total);
    endfunction

    function int unsigned outstanding();
      return awaited.size();
    endfunction
  endclass

endpackage

// ----- tb/sv/tb_tlb_fifo_lookup_insert.sv -----
// Top of the translation buffer testbench: clock, reset, request driver,
// result collector and test phases. Depends on tfli_pkg, tfli_if, tfli_tb_pkg
// and the tlb_fifo_lookup_insert RTL.
module tb_tlb_fifo_lookup_insert;
  timeunit 1ns;
  timeprecision 1ps;
  import tfli_pkg::*;
  import tfli_tb_pkg::*;

  localparam int MAX_CYCLES   = 200000;
  localparam int LONG_HOLD    = 150;
  localparam int PHASE_ITEMS  = 300;
  localparam int POOL_SIZE    = 16;
  localparam int SETTLE_TICKS = 5;

  logic clk;
  logic rst;

  tfli_in_if  in_ch();
  tfli_out_if out_ch();

  tlb_fifo_lookup_insert dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  tlb_scoreboard sb;

  int          send_gap_max;
  int          recv_stall_max;
  bit          hold_request;
  int unsigned cycle_count;

  // pages seen recently, so random lookups hit often
  logic [PAGE_BITS-1:0] page_pool[POOL_SIZE];

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("tlb_fifo_lookup_insert regression: fail");
      $finish;
    end
  end

  // Offer one request after a random gap; return once it is accepted.
  task automatic offer_request(logic func, logic [PAGE_BITS-1:0] page,
                               logic [FRAME_BITS-1:0] frame);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) begin
        in_ch.func         = 1'($urandom_range(0, 1));
        in_ch.page_number  = PAGE_BITS'($urandom);
        in_ch.frame_number = FRAME_BITS'($urandom);
        @(negedge clk);
      end
    end
    in_ch.valid        = 1'b1;
    in_ch.func         = func;
    in_ch.page_number  = page;
    in_ch.frame_number = frame;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(func, page, frame);
  endtask

  // Drop valid and wait for every pending result.
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // Random request: mostly pages from the pool so lookups hit and tags repeat.
  task automatic offer_random_request();
    logic                  func;
    logic [PAGE_BITS-1:0]  page;
    logic [FRAME_BITS-1:0] frame;
    int                    pick;
    func  = ($urandom_range(0, 9) < 6) ? FUNC_LOOKUP : FUNC_INSERT;
    frame = FRAME_BITS'($urandom);
    pick  = $urandom_range(0, 9);
    if (pick < 6)
      page = page_pool[$urandom_range(0, POOL_SIZE - 1)];
    else if (pick < 9)
      page = PAGE_BITS'($urandom);
    else
      page = $urandom_range(0, 1) ? '1 : '0;
    if (func == FUNC_INSERT)
      page_pool[$urandom_range(0, POOL_SIZE - 1)] = page;
    offer_request(func, page, frame);
  endtask

  task automatic run_random_phase(int gap_max, int stall_max);
    send_gap_max   = gap_max;
    recv_stall_max = stall_max;
    repeat (PHASE_ITEMS) offer_random_request();
    drain_results();
  endtask

  // Result collector: random stalls, plus one long hold on request.
  initial begin
    int          stall;
    tlb_result_t got;
    wait (rst === 1'b0);
    forever begin
      if (hold_request) begin
        stall        = LONG_HOLD;
        hold_request = 1'b0;
      end else begin
        stall = $urandom_range(0, recv_stall_max);
      end
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got.hit          = out_ch.hit;
      got.found_frame  = out_ch.found_frame;
      got.lookup_total = out_ch.lookup_total;
      got.hit_total    = out_ch.hit_total;
      sb.check_result(got, $time);
    end
  end

  // Main sequence
  initial begin
    sb                 = new();
    rst                = 1'b1;
    in_ch.valid        = 1'b0;
    in_ch.func         = FUNC_LOOKUP;
    in_ch.page_number  = '0;
    in_ch.frame_number = '0;
    out_ch.ready       = 1'b0;
    hold_request       = 1'b0;
    send_gap_max       = 3;
    recv_stall_max     = 3;
    foreach (page_pool[k]) page_pool[k] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // lookups on an empty buffer miss
    offer_request(FUNC_LOOKUP, 20'h00000, 20'hFFFFF);
    offer_request(FUNC_LOOKUP, 20'hFFFFF, 20'h00000);
    // fill from the top; the same tag twice
    offer_request(FUNC_INSERT, 20'hFFFFF, 20'hFFFFF);
    offer_request(FUNC_INSERT, 20'h00000, 20'h00000);
    offer_request(FUNC_INSERT, 20'hABCDE, 20'h12345);
    offer_request(FUNC_INSERT, 20'hABCDE, 20'h54321);
    // hits, zero frame, duplicate tag gives the lowest index
    offer_request(FUNC_LOOKUP, 20'hFFFFF, 20'h00000);
    offer_request(FUNC_LOOKUP, 20'h00000, 20'hFFFFF);
    offer_request(FUNC_LOOKUP, 20'hABCDE, 20'h00000);
    // fill up, then one more to evict the oldest
    offer_request(FUNC_INSERT, 20'h55555, 20'hAAAAA);
    offer_request(FUNC_INSERT, 20'hAAAAA, 20'h55555);
    offer_request(FUNC_INSERT, 20'h00001, 20'h80000);
    offer_request(FUNC_INSERT, 20'h80000, 20'h00001);
    offer_request(FUNC_INSERT, 20'h12345, 20'h6789A);
    offer_request(FUNC_LOOKUP, 20'hFFFFF, 20'h00000);
    offer_request(FUNC_LOOKUP, 20'h12345, 20'h00000);
    offer_request(FUNC_LOOKUP, 20'hABCDE, 20'h00000);
    drain_results();

    run_random_phase(10, 10);
    // back-to-back requests against a long receiver hold
    hold_request = 1'b1;
    run_random_phase(0, 0);
    run_random_phase(0, 10);
    run_random_phase(10, 0);

    repeat (SETTLE_TICKS) @(posedge clk);
    if (sb.failures == 0 && sb.outstanding() == 0)
      $display("tlb_fifo_lookup_insert regression: pass");
    else
      $display("tlb_fifo_lookup_insert regression: fail");
    $finish;
  end

endmodule
